/* rtl/tempo_keypad_beat_generator_unit_defines.svh */
// Assertion macros for the tempo keypad beat generator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TEMPO_KEYPAD_BEAT_GENERATOR_UNIT_DEFINES_SVH
`define TEMPO_KEYPAD_BEAT_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge out of reset.
`define TKBG_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("tkbg assertion failed");

// A consequence that must hold in the same cycle as its antecedent.
`define TKBG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tkbg assertion failed");

// A consequence that must hold in the cycle after its antecedent.
`define TKBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tkbg assertion failed");

`else

`define TKBG_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TKBG_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TKBG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tkbg_pkg.sv */
// Shared constants for the tempo keypad beat generator: field widths, key codes,
// tempo limits and divider sizing. Depends on nothing.
package tkbg_pkg;

	localparam int TEMPO_W   = 8;
	localparam int KEY_W     = 8;
	localparam int BEEP_W    = 8;
	localparam int MS_W      = 10;
	localparam int DIGIT_W   = 4;
	localparam int NUM_DIGITS = 3;
	localparam int IDX_W     = 2;
	localparam int VALUE_W   = 10;

	localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 8'd60;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 8'd240;
	localparam logic [TEMPO_W-1:0] TEMPO_STEP  = 8'd10;
	localparam logic [MS_W-1:0]    PERIOD_INIT = 10'd1000;
	localparam logic [BEEP_W-1:0]  BEEP_INIT   = 8'd100;

	// Restoring division of a fixed dividend, one quotient bit per cycle.
	localparam int                  DIVIDEND_W    = 16;
	localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE = 16'd60000;
	localparam int                  DIV_CNT_W     = 4;

	localparam logic [KEY_W-1:0] KEY_DIGIT_0 = 8'd48;
	localparam logic [KEY_W-1:0] KEY_DIGIT_9 = 8'd57;
	localparam logic [KEY_W-1:0] KEY_ENTER   = 8'd13;
	localparam logic [KEY_W-1:0] KEY_UP      = 8'd72;
	localparam logic [KEY_W-1:0] KEY_DOWN    = 8'd80;
	localparam logic [KEY_W-1:0] KEY_LEFT    = 8'd75;
	localparam logic [KEY_W-1:0] KEY_RIGHT   = 8'd77;
	localparam logic [KEY_W-1:0] KEY_SPACE   = 8'd32;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Configuration register map.
	localparam int   PADDR_W       = 3;
	localparam int   PDATA_W       = 32;
	localparam logic REG_BEEP_MS   = 1'b0;

endpackage

/* rtl/tkbg_if.sv */
// Handshake interfaces for the command and result channels of the beat generator.
// Depends on tkbg_pkg for the field widths.
interface tkbg_cmd_if;
	logic                      valid;
	logic                      ready;
	logic                      operation;
	logic [tkbg_pkg::KEY_W-1:0] key_code;

	modport source (output valid, output operation, output key_code, input ready);
	modport sink   (input valid, input operation, input key_code, output ready);
endinterface

interface tkbg_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tkbg_pkg::TEMPO_W-1:0] tempo_bpm;
	logic                        beep_on;
	logic                        beat_start;
	logic                        key_invalid;

	modport source (output valid, output tempo_bpm, output beep_on, output beat_start,
		output key_invalid, input ready);
	modport sink   (input valid, input tempo_bpm, input beep_on, input beat_start,
		input key_invalid, output ready);
endinterface

/* rtl/tempo_keypad_beat_generator_unit.sv */
// Tempo keypad beat generator: keypad tempo editing and millisecond beat timing.
// Depends on tkbg_pkg, the interfaces in tkbg_if.sv and the assertion macros header.
//
// Usage
// The cmd channel carries one transaction per key press or per one-millisecond tick;
// the rsp channel returns exactly one transaction for each, carrying the tempo after
// the item, the beep and beat-start flags of a tick and the invalid-key flag of a key.
// Key presses and ticks that fall inside a beat are answered directly: the result
// sits in the output register on the cycle after the command is taken. A tick that
// starts a beat latches the period 60000/tempo, which a bit-serial restoring divider
// works out one quotient bit per cycle in the divide state; the write-back state then
// writes the result once the output register is free.
// The block holds one command at a time. It takes the next command while a result
// still waits in the output register, provided that register is being emptied in the
// same cycle; while the receiver stalls, results are held and commands wait.
// The beep length register sits at byte address 0 of the APB-style port; it should
// only be written while no command is outstanding.
// Reset (arst_n low) sets the tempo to 60, clears the digit buffer and the
// millisecond count, sets the latched period to 1000 and the beep length to 100.
`include "tempo_keypad_beat_generator_unit_defines.svh"

module tempo_keypad_beat_generator_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	tkbg_cmd_if.sink                          cmd,
	tkbg_rsp_if.source                        rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tkbg_pkg::PADDR_W-1:0]      paddr,
	input  logic [tkbg_pkg::PDATA_W-1:0]      pwdata,
	output logic [tkbg_pkg::PDATA_W-1:0]      prdata,
	output logic                              pready
);

	// Sequencer: idle, stepping the divider, then writing the beat-start result.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_WRB  = 3'b100
	} state_t;

	state_t state_q;

	// Architectural state.
	logic [tkbg_pkg::TEMPO_W-1:0] tempo_q;
	logic [tkbg_pkg::DIGIT_W-1:0] digit_q [tkbg_pkg::NUM_DIGITS];
	logic [tkbg_pkg::IDX_W-1:0]   idx_q;
	logic [tkbg_pkg::MS_W-1:0]    ms_count_q;
	logic [tkbg_pkg::MS_W-1:0]    beat_period_q;
	logic [tkbg_pkg::BEEP_W-1:0]  beep_ms_q;

	// Divider state: partial remainder, step counter and quotient shift register.
	logic [tkbg_pkg::TEMPO_W-1:0]   rem_q;
	logic [tkbg_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [tkbg_pkg::MS_W-1:0]      quo_q;

	// Output register.
	logic                         rsp_valid_q;
	logic [tkbg_pkg::TEMPO_W-1:0] rsp_tempo_q;
	logic                         rsp_beep_q;
	logic                         rsp_start_q;
	logic                         rsp_invalid_q;

	logic rsp_free;
	logic rsp_load;
	logic cmd_fire;
	logic cfg_write;

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && rsp_free;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// A new result enters the output register this cycle.
	assign rsp_load = (cmd_fire && ((cmd.operation == tkbg_pkg::OP_KEY) || (ms_count_q != '0)))
		|| ((state_q == ST_WRB) && rsp_free);

	assign rsp.valid       = rsp_valid_q;
	assign rsp.tempo_bpm   = rsp_tempo_q;
	assign rsp.beep_on     = rsp_beep_q;
	assign rsp.beat_start  = rsp_start_q;
	assign rsp.key_invalid = rsp_invalid_q;

	// Configuration port: one register, decoded on the word address bit.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == tkbg_pkg::REG_BEEP_MS) ?
		{{(tkbg_pkg::PDATA_W-tkbg_pkg::BEEP_W){1'b0}}, beep_ms_q} : '0;

	// Key decode: digit buffer, commit with clamping, arrow steps.
	logic [tkbg_pkg::TEMPO_W-1:0] tempo_nx;
	logic [tkbg_pkg::DIGIT_W-1:0] digit_nx [tkbg_pkg::NUM_DIGITS];
	logic [tkbg_pkg::DIGIT_W-1:0] commit_src [tkbg_pkg::NUM_DIGITS];
	logic [tkbg_pkg::IDX_W-1:0]   idx_nx;
	logic [tkbg_pkg::VALUE_W-1:0] commit_val;
	logic                         commit_en;
	logic                         key_bad;
	logic                         is_digit;

	assign is_digit = (cmd.key_code >= tkbg_pkg::KEY_DIGIT_0) &&
		(cmd.key_code <= tkbg_pkg::KEY_DIGIT_9);

	always_comb begin
		tempo_nx   = tempo_q;
		digit_nx   = digit_q;
		commit_src = digit_q;
		idx_nx     = idx_q;
		commit_en  = 1'b0;
		key_bad    = 1'b0;
		if (is_digit) begin
			// Digit codes carry their value in the low nibble.
			if (idx_q == tkbg_pkg::IDX_W'(tkbg_pkg::NUM_DIGITS - 1)) begin
				commit_src[tkbg_pkg::NUM_DIGITS-1] = cmd.key_code[tkbg_pkg::DIGIT_W-1:0];
				commit_en = 1'b1;
				for (int i = 0; i < tkbg_pkg::NUM_DIGITS; i++) begin
					digit_nx[i] = '0;
				end
				idx_nx = '0;
			end else begin
				digit_nx[idx_q] = cmd.key_code[tkbg_pkg::DIGIT_W-1:0];
				idx_nx = idx_q + 1'b1;
			end
		end else begin
			case (cmd.key_code)
				tkbg_pkg::KEY_ENTER: begin
					commit_en = 1'b1;
				end
				tkbg_pkg::KEY_UP: begin
					if (tempo_q < tkbg_pkg::TEMPO_MAX) tempo_nx = tempo_q + 1'b1;
				end
				tkbg_pkg::KEY_DOWN: begin
					if (tempo_q > tkbg_pkg::TEMPO_MIN) tempo_nx = tempo_q - 1'b1;
				end
				tkbg_pkg::KEY_LEFT: begin
					tempo_nx = (tempo_q >= tkbg_pkg::TEMPO_MIN + tkbg_pkg::TEMPO_STEP) ?
						tempo_q - tkbg_pkg::TEMPO_STEP : tkbg_pkg::TEMPO_MIN;
				end
				tkbg_pkg::KEY_RIGHT: begin
					tempo_nx = (tempo_q <= tkbg_pkg::TEMPO_MAX - tkbg_pkg::TEMPO_STEP) ?
						tempo_q + tkbg_pkg::TEMPO_STEP : tkbg_pkg::TEMPO_MAX;
				end
				tkbg_pkg::KEY_SPACE: begin
					// Recognised, but pause is not implemented.
				end
				default: begin
					key_bad = 1'b1;
				end
			endcase
		end

		commit_val = tkbg_pkg::VALUE_W'(commit_src[0]) * tkbg_pkg::VALUE_W'(100)
			+ tkbg_pkg::VALUE_W'(commit_src[1]) * tkbg_pkg::VALUE_W'(10)
			+ tkbg_pkg::VALUE_W'(commit_src[2]);
		if (commit_en) begin
			if (commit_val < tkbg_pkg::VALUE_W'(tkbg_pkg::TEMPO_MIN)) begin
				tempo_nx = tkbg_pkg::TEMPO_MIN;
			end else if (commit_val > tkbg_pkg::VALUE_W'(tkbg_pkg::TEMPO_MAX)) begin
				tempo_nx = tkbg_pkg::TEMPO_MAX;
			end else begin
				tempo_nx = commit_val[tkbg_pkg::TEMPO_W-1:0];
			end
		end
	end

	// Tick timing. At a beat start the count is zero and the fresh quotient is the period.
	logic [tkbg_pkg::MS_W-1:0] period_use;
	logic [tkbg_pkg::MS_W-1:0] ms_inc;
	logic [tkbg_pkg::MS_W-1:0] ms_nx;
	logic                      beep_now;

	assign period_use = (state_q == ST_WRB) ? quo_q : beat_period_q;
	assign ms_inc     = ms_count_q + 1'b1;
	assign ms_nx      = (ms_inc >= period_use) ? '0 : ms_inc;
	assign beep_now   = ms_count_q < tkbg_pkg::MS_W'(beep_ms_q);

	// Divider step: bring down the next dividend bit, subtract the tempo if it fits.
	logic [tkbg_pkg::TEMPO_W:0]   trial;
	logic                         q_bit;
	logic                         div_bit;

	assign div_bit = tkbg_pkg::MS_PER_MINUTE[tkbg_pkg::DIV_CNT_W'(tkbg_pkg::DIVIDEND_W-1) - cnt_q];
	assign trial   = {rem_q, div_bit};
	assign q_bit   = trial >= {1'b0, tempo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tempo_q       <= tkbg_pkg::TEMPO_MIN;
			for (int i = 0; i < tkbg_pkg::NUM_DIGITS; i++) begin
				digit_q[i] <= '0;
			end
			idx_q         <= '0;
			ms_count_q    <= '0;
			beat_period_q <= tkbg_pkg::PERIOD_INIT;
			beep_ms_q     <= tkbg_pkg::BEEP_INIT;
			rem_q         <= '0;
			cnt_q         <= '0;
			quo_q         <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_tempo_q   <= '0;
			rsp_beep_q    <= 1'b0;
			rsp_start_q   <= 1'b0;
			rsp_invalid_q <= 1'b0;
		end else begin
			if (cfg_write && (paddr[2] == tkbg_pkg::REG_BEEP_MS)) begin
				beep_ms_q <= pwdata[tkbg_pkg::BEEP_W-1:0];
			end

			if (rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						if (cmd.operation == tkbg_pkg::OP_KEY) begin
							tempo_q       <= tempo_nx;
							digit_q       <= digit_nx;
							idx_q         <= idx_nx;
							rsp_valid_q   <= 1'b1;
							rsp_tempo_q   <= tempo_nx;
							rsp_beep_q    <= 1'b0;
							rsp_start_q   <= 1'b0;
							rsp_invalid_q <= key_bad;
						end else if (ms_count_q != '0) begin
							ms_count_q    <= ms_nx;
							rsp_valid_q   <= 1'b1;
							rsp_tempo_q   <= tempo_q;
							rsp_beep_q    <= beep_now;
							rsp_start_q   <= 1'b0;
							rsp_invalid_q <= 1'b0;
						end else begin
							// Beat start: work out 60000 / tempo first.
							rem_q   <= '0;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= q_bit ? trial[tkbg_pkg::TEMPO_W-1:0] - tempo_q
						: trial[tkbg_pkg::TEMPO_W-1:0];
					quo_q <= {quo_q[tkbg_pkg::MS_W-2:0], q_bit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tkbg_pkg::DIV_CNT_W'(tkbg_pkg::DIVIDEND_W-1)) begin
						state_q <= ST_WRB;
					end
				end
				ST_WRB: begin
					if (rsp_free) begin
						beat_period_q <= quo_q;
						ms_count_q    <= ms_nx;
						rsp_valid_q   <= 1'b1;
						rsp_tempo_q   <= tempo_q;
						rsp_beep_q    <= beep_now;
						rsp_start_q   <= 1'b1;
						rsp_invalid_q <= 1'b0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The tempo never leaves its legal range, whatever keys arrive.
	`TKBG_ASSERT_ALWAYS(a_tempo_range, clk, arst_n,
		(tempo_q >= tkbg_pkg::TEMPO_MIN) && (tempo_q <= tkbg_pkg::TEMPO_MAX))
	// The millisecond count always wraps before reaching the latched period.
	`TKBG_ASSERT_ALWAYS(a_ms_below_period, clk, arst_n, ms_count_q < beat_period_q)
	// No command is taken while the divider or the write-back state is busy.
	`TKBG_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, !cmd.ready)
	// The last divider step hands over to the write-back state.
	`TKBG_ASSERT_NEXT(a_div_to_wrb, clk, arst_n,
		(state_q == ST_DIV) && (cnt_q == tkbg_pkg::DIV_CNT_W'(tkbg_pkg::DIVIDEND_W-1)),
		state_q == ST_WRB)

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the tempo keypad beat generator: key presses and
// millisecond ticks against a cycle-free predictor. Depends on tkbg_pkg, the
// tkbg_cmd_if/tkbg_rsp_if interfaces and the tempo_keypad_beat_generator_unit RTL.
`timescale 1ns / 100ps

module tb_top;
	import tkbg_pkg::*;

	// Key code that the block does not recognise, used by name in the directed part.
	localparam logic [KEY_W-1:0] KEY_ESCAPE = 8'd27;
	// The beep length register is register 0 of the map, at byte address 4*index.
	localparam logic [PADDR_W-1:0] BEEP_ADDR = PADDR_W'(4 * int'(REG_BEEP_MS));

	// One result transaction, field by field as the rsp channel carries it.
	typedef struct packed {
		logic [TEMPO_W-1:0] tempo_bpm;
		logic               beep_on;
		logic               beat_start;
		logic               key_invalid;
	} beat_result_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	tkbg_cmd_if cmd_ch();
	tkbg_rsp_if rsp_ch();

	tempo_keypad_beat_generator_unit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predicted state of the block. The initial values are the block's reset state;
	// reset is applied exactly once, so these never need to be reloaded.
	logic [TEMPO_W-1:0] tempo_now = TEMPO_MIN;
	logic [DIGIT_W-1:0] typed_digits [NUM_DIGITS] = '{default: '0};
	int                 digit_pos = 0;
	logic [MS_W-1:0]    ms_elapsed = '0;
	logic [MS_W-1:0]    period_ms = PERIOD_INIT;
	logic [BEEP_W-1:0]  beep_len = BEEP_INIT;

	// Results predicted for accepted commands, oldest first.
	beat_result_t pending_results[$];
	beat_result_t want;

	// Knobs shared between the stimulus tasks and the result sink.
	bit sender_gaps_on = 1'b1;
	bit receiver_stalls_on = 1'b1;
	int receiver_hold_cycles = 0;

	int mismatch_count = 0;
	int results_checked = 0;
	int beats_seen = 0;
	int beeps_seen = 0;
	int rejected_keys = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The typed value of the digit buffer, clamped into the legal tempo range.
	function automatic logic [TEMPO_W-1:0] typed_tempo();
		int value;
		value = 100 * int'(typed_digits[0]) + 10 * int'(typed_digits[1])
			+ int'(typed_digits[2]);
		if (value < int'(TEMPO_MIN)) value = int'(TEMPO_MIN);
		if (value > int'(TEMPO_MAX)) value = int'(TEMPO_MAX);
		return TEMPO_W'(value);
	endfunction

	// Applies one accepted command to the predicted state and returns the result the
	// block must give for it.
	function automatic beat_result_t advance_tempo_model(input logic op,
			input logic [KEY_W-1:0] code);
		beat_result_t res;
		int next_ms;
		res = '0;
		if (op == OP_KEY) begin
			if (code >= KEY_DIGIT_0 && code <= KEY_DIGIT_9) begin
				typed_digits[digit_pos] = DIGIT_W'(code - KEY_DIGIT_0);
				digit_pos++;
				// The third digit commits the buffer and starts a fresh one.
				if (digit_pos == NUM_DIGITS) begin
					digit_pos = 0;
					tempo_now = typed_tempo();
					typed_digits = '{default: '0};
				end
			end else if (code == KEY_ENTER) begin
				// Enter commits whatever has been typed but leaves the buffer alone.
				tempo_now = typed_tempo();
			end else if (code == KEY_UP) begin
				if (tempo_now < TEMPO_MAX) tempo_now = tempo_now + 1'b1;
			end else if (code == KEY_DOWN) begin
				if (tempo_now > TEMPO_MIN) tempo_now = tempo_now - 1'b1;
			end else if (code == KEY_LEFT) begin
				tempo_now = (tempo_now >= TEMPO_MIN + TEMPO_STEP) ?
					tempo_now - TEMPO_STEP : TEMPO_MIN;
			end else if (code == KEY_RIGHT) begin
				tempo_now = (int'(tempo_now) + int'(TEMPO_STEP) <= int'(TEMPO_MAX)) ?
					tempo_now + TEMPO_STEP : TEMPO_MAX;
			end else if (code != KEY_SPACE) begin
				res.key_invalid = 1'b1;
			end
		end else begin
			// A tick at count zero opens a beat and latches the period for it, so a
			// tempo edited mid-beat only counts from the next beat on.
			if (ms_elapsed == '0) begin
				period_ms = MS_W'(int'(MS_PER_MINUTE) / int'(tempo_now));
				res.beat_start = 1'b1;
			end
			res.beep_on = int'(ms_elapsed) < int'(beep_len);
			next_ms = int'(ms_elapsed) + 1;
			ms_elapsed = (next_ms >= int'(period_ms)) ? '0 : MS_W'(next_ms);
		end
		res.tempo_bpm = tempo_now;
		return res;
	endfunction

	// Offers one command after a random gap and waits for the block to take it. The
	// valid line is left high on return so that a following command can go out on the
	// very next cycle; any other caller must lower it before letting time pass.
	task automatic send_item(input logic op, input logic [KEY_W-1:0] code);
		int gap;
		gap = sender_gaps_on ? $urandom_range(0, 13) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.key_code <= code;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_results.push_back(advance_tempo_model(op, code));
	endtask

	task automatic press(input logic [KEY_W-1:0] code);
		send_item(OP_KEY, code);
	endtask

	// A tick carries a random key code, which the block must ignore.
	task automatic tick(input int count);
		repeat (count) send_item(OP_TICK, KEY_W'($urandom_range(0, 255)));
	endtask

	// Stops offering commands and waits until every predicted result has come back.
	task automatic wait_for_idle();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	// Writes the beep length over the APB-style port while the block is idle, then
	// reads it back.
	task automatic write_beep_length(input logic [BEEP_W-1:0] len);
		logic [PDATA_W-1:0] readback;
		wait_for_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= BEEP_ADDR;
		pwdata <= PDATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		beep_len = len;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback[BEEP_W-1:0] !== len) begin
			$display("%0t: beep_ms read back expected %0d, got %0d", $time, len,
				readback[BEEP_W-1:0]);
			mismatch_count++;
		end
	endtask

	// Random traffic. Most key activity is whole three-digit tempos, since only
	// complete entries move the tempo far; the rest is arrows, enter, space, single
	// digits that knock the buffer out of step, and arbitrary codes.
	task automatic run_random_traffic(input int count, input int tick_pct);
		int sent;
		int roll;
		int value;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(0, 99);
			if (roll < tick_pct) begin
				tick(1);
				sent++;
			end else if (roll < tick_pct + (100 - tick_pct) / 3) begin
				value = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) :
					$urandom_range(int'(TEMPO_MIN), int'(TEMPO_MAX));
				press(KEY_DIGIT_0 + KEY_W'(value / 100));
				press(KEY_DIGIT_0 + KEY_W'((value / 10) % 10));
				press(KEY_DIGIT_0 + KEY_W'(value % 10));
				sent += 3;
			end else begin
				case ($urandom_range(0, 9))
					0, 1: press(KEY_DIGIT_0 + KEY_W'($urandom_range(0, 9)));
					2: press(KEY_UP);
					3: press(KEY_DOWN);
					4: press(KEY_LEFT);
					5: press(KEY_RIGHT);
					6: press(KEY_ENTER);
					7: press(KEY_SPACE);
					default: press(KEY_W'($urandom_range(0, 255)));
				endcase
				sent++;
			end
		end
	endtask

	// Directed key editing from reset: clamping of typed values at both ends, arrows
	// at both limits, the ten-step arrows saturating, enter on an empty and on a part
	// filled buffer, space, and codes the block must reject. No ticks are sent here, so
	// the first beat of the next test starts at count zero.
	task automatic test_key_editing();
		press(KEY_DIGIT_9); press(KEY_DIGIT_9); press(KEY_DIGIT_9);
		press(KEY_UP);
		press(KEY_RIGHT);
		press(KEY_DIGIT_0); press(KEY_DIGIT_0); press(KEY_DIGIT_0);
		press(KEY_DOWN);
		press(KEY_LEFT);
		press(KEY_DIGIT_0); press(KEY_DIGIT_0 + 8'd6); press(KEY_DIGIT_0 + 8'd5);
		press(KEY_LEFT);
		press(KEY_RIGHT);
		press(KEY_UP);
		press(KEY_DOWN);
		press(KEY_ENTER);
		press(KEY_DIGIT_0 + 8'd2); press(KEY_DIGIT_0 + 8'd3); press(KEY_ENTER);
		press(KEY_DIGIT_0 + 8'd1);
		press(KEY_RIGHT);
		press(KEY_SPACE);
		press(KEY_ESCAPE);
		press('0);
		press('1);
	endtask

	// The tempo is 240 here, so the first beat lasts 250 ticks, shorter than a beep of
	// 255: the beep has to cover the whole beat. Partway through, the tempo is typed
	// down to 120, which must only take effect at the following beat start.
	task automatic test_long_beep_and_tempo_change();
		write_beep_length(8'd255);
		tick(100);
		press(KEY_DIGIT_0 + 8'd1); press(KEY_DIGIT_0 + 8'd2); press(KEY_DIGIT_0);
		tick(160);
	endtask

	// A beep length of zero must never sound.
	task automatic test_silent_beep();
		write_beep_length('0);
		run_random_traffic(200, 90);
	endtask

	// A beep length of 1, one of 249 and a random value in between.
	task automatic test_beep_sweep();
		write_beep_length(8'd1);
		run_random_traffic(300, 70);
		write_beep_length(8'd249);
		run_random_traffic(300, 70);
		write_beep_length(BEEP_W'($urandom_range(2, 248)));
		run_random_traffic(300, 70);
	endtask

	// Back-to-back transactions on both channels.
	task automatic test_unthrottled();
		sender_gaps_on = 1'b0;
		receiver_stalls_on = 1'b0;
		run_random_traffic(200, 80);
		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while commands keep coming, so the
	// output register fills and the block has to stall its command channel.
	task automatic test_output_backpressure();
		write_beep_length(BEEP_W'($urandom_range(1, 249)));
		sender_gaps_on = 1'b0;
		receiver_hold_cycles = 300;
		run_random_traffic(150, 70);
		sender_gaps_on = 1'b1;
	endtask

	// Result sink: draws a stall before each transaction, or serves a requested hold.
	initial begin : result_sink
		int pause;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (receiver_hold_cycles > 0) begin
				pause = receiver_hold_cycles;
				receiver_hold_cycles = 0;
			end else begin
				pause = receiver_stalls_on ? $urandom_range(0, 13) : 0;
			end
			if (pause > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Every result transaction is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got tempo %0d beep %0b %s%0b %s%0b",
					$time, rsp_ch.tempo_bpm, rsp_ch.beep_on, "start ",
					rsp_ch.beat_start, "invalid ", rsp_ch.key_invalid);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				beats_seen += int'(want.beat_start);
				beeps_seen += int'(want.beep_on);
				rejected_keys += int'(want.key_invalid);
				if (rsp_ch.tempo_bpm !== want.tempo_bpm) begin
					$display("%0t: tempo_bpm expected %0d, got %0d", $time,
						want.tempo_bpm, rsp_ch.tempo_bpm);
					mismatch_count++;
				end
				if (rsp_ch.beep_on !== want.beep_on) begin
					$display("%0t: beep_on expected %0b, got %0b", $time,
						want.beep_on, rsp_ch.beep_on);
					mismatch_count++;
				end
				if (rsp_ch.beat_start !== want.beat_start) begin
					$display("%0t: beat_start expected %0b, got %0b", $time,
						want.beat_start, rsp_ch.beat_start);
					mismatch_count++;
				end
				if (rsp_ch.key_invalid !== want.key_invalid) begin
					$display("%0t: key_invalid expected %0b, got %0b", $time,
						want.key_invalid, rsp_ch.key_invalid);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_KEY;
		cmd_ch.key_code <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_key_editing();
		test_long_beep_and_tempo_change();
		test_silent_beep();
		test_beep_sweep();
		test_unthrottled();
		test_output_backpressure();

		wait_for_idle();
		$display("Checked %0d result transactions: %0d beat starts, %0d beeping ticks, %0d %s",
			results_checked, beats_seen, beeps_seen, rejected_keys, "rejected keys.");
		$display("Beep lengths 0, 1, 249, 255 and random; typed, stepped and clamped tempos.");
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Guard against a hung handshake: far longer than the slowest legal run.
	initial begin
		#4_000_000;
		$display("Timeout with %0d results outstanding", pending_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tkbg_pkg.sv
rtl/tkbg_if.sv
rtl/tempo_keypad_beat_generator_unit.sv
tb/tb_top.sv
